>>> src/mift_pkg.sv
// Shared types and constants of the message identifier frequency table.
package mift_pkg;

  localparam int ID_W   = 29;
  localparam int CNT_W  = 32;
  localparam int RANK_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_COUNT  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_NEW    = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_REPORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [RANK_W-1:0]   rank;
    logic [ID_W-1:0]     entry_id;
    logic [CNT_W-1:0]    entry_count;
    logic                last;
  } res_t;

endpackage

>>> src/mift_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mift_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/mift_engine.sv
// Sequencer that scans the slot memories for count updates and top-K ranking.
module mift_engine
  import mift_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int TOP_K       = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_func,
  input  logic [ID_W-1:0]                in_key,
  output logic                           in_ready,
  input  logic                           out_free,
  output logic                           push,
  output res_t                           res,
  output logic                           rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [CNT_W-1:0]               cnt_rdata,
  input  logic [ID_W-1:0]                id_rdata,
  output logic                           cnt_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] cnt_waddr,
  output logic [CNT_W-1:0]               cnt_wdata,
  output logic                           id_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] id_waddr,
  output logic [ID_W-1:0]                id_wdata
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int RKW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [AW-1:0]  LAST_IDX  = AW'(TABLE_DEPTH - 1);
  localparam logic [RKW-1:0] LAST_RANK = RKW'(TOP_K - 1);

  state_t            state_r, state_nxt;
  logic              func_r, func_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              vld_r, vld_nxt;
  logic [AW-1:0]     vidx_r, vidx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic              best_found_r, best_found_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [CNT_W-1:0]  prev_cnt_r, prev_cnt_nxt;
  logic [AW-1:0]     prev_idx_r, prev_idx_nxt;
  logic              first_r, first_nxt;
  logic [RKW-1:0]    rank_r, rank_nxt;
  res_t              res_r, res_nxt;

  logic              scan_v, occ, hit, scan_end, cnt_fin, rep_fin;
  logic              elig, better, free_now, found_now;
  logic [AW-1:0]     free_sel;
  logic [CNT_W-1:0]  cnt_inc, pick_cnt;
  logic [ID_W-1:0]   pick_id;
  logic [AW-1:0]     pick_idx;
  logic [RKW+RANK_W-1:0] rank_ext;

  // Scan events on the data returned in the cycle after each read
  assign scan_v   = (state_r == ST_SCAN) && vld_r;
  assign occ      = (cnt_rdata != '0);
  assign hit      = scan_v && (func_r == FUNC_COUNT) && occ && (id_rdata == key_r);
  assign scan_end = scan_v && (vidx_r == LAST_IDX);
  assign cnt_fin  = hit || (scan_end && (func_r == FUNC_COUNT));
  assign rep_fin  = scan_end && (func_r == FUNC_REPORT);
  assign cnt_inc  = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

  assign free_now = free_found_r || !occ;
  assign free_sel = free_found_r ? free_idx_r : vidx_r;

  // Eligible entries come strictly after the previous pick in rank order
  assign elig   = occ && (first_r || (cnt_rdata < prev_cnt_r) ||
                          ((cnt_rdata == prev_cnt_r) && (vidx_r > prev_idx_r)));
  assign better = elig && (!best_found_r || (cnt_rdata > best_cnt_r));

  assign found_now = best_found_r || better;
  assign pick_cnt  = better ? cnt_rdata : best_cnt_r;
  assign pick_id   = better ? id_rdata  : best_id_r;
  assign pick_idx  = better ? vidx_r    : best_idx_r;
  assign rank_ext  = {{RANK_W{1'b0}}, rank_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_fin || rep_fin) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if ((func_r == FUNC_REPORT) && (rank_r != LAST_RANK)) state_nxt = ST_SCAN;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    rd_en     = (state_r == ST_SCAN) && !iss_done_r;
    rd_addr   = addr_r;
    push      = (state_r == ST_EMIT) && out_free;
    res       = res_r;
    cnt_we    = 1'b0;
    cnt_waddr = addr_r;
    cnt_wdata = '0;
    id_we     = 1'b0;
    id_waddr  = free_sel;
    id_wdata  = key_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_we = 1'b1;
      end
      ST_SCAN: begin
        if (hit) begin
          cnt_we    = 1'b1;
          cnt_waddr = vidx_r;
          cnt_wdata = cnt_inc;
        end else if (cnt_fin && free_now) begin
          cnt_we    = 1'b1;
          cnt_waddr = free_sel;
          cnt_wdata = CNT_W'(1);
          id_we     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_comb begin
    func_nxt       = func_r;
    key_nxt        = key_r;
    addr_nxt       = addr_r;
    iss_done_nxt   = iss_done_r;
    vld_nxt        = rd_en;
    vidx_nxt       = addr_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_cnt_nxt   = best_cnt_r;
    best_id_nxt    = best_id_r;
    prev_cnt_nxt   = prev_cnt_r;
    prev_idx_nxt   = prev_idx_r;
    first_nxt      = first_r;
    rank_nxt       = rank_r;
    res_nxt        = res_r;

    if (state_r == ST_CLEAR) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == LAST_IDX) addr_nxt = '0;
    end

    if (state_r == ST_IDLE && in_valid) begin
      func_nxt       = in_func;
      key_nxt        = in_key;
      addr_nxt       = '0;
      iss_done_nxt   = 1'b0;
      free_found_nxt = 1'b0;
      best_found_nxt = 1'b0;
      first_nxt      = 1'b1;
      rank_nxt       = '0;
    end

    if (rd_en) begin
      if (addr_r == LAST_IDX) begin
        iss_done_nxt = 1'b1;
        addr_nxt     = '0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end

    if (scan_v) begin
      if (!occ && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = vidx_r;
      end
      if (better) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = vidx_r;
        best_cnt_nxt   = cnt_rdata;
        best_id_nxt    = id_rdata;
      end
    end

    if (cnt_fin) begin
      res_nxt.rank     = '0;
      res_nxt.entry_id = key_r;
      res_nxt.last     = 1'b1;
      if (hit) begin
        res_nxt.status      = STAT_HIT;
        res_nxt.entry_count = cnt_inc;
      end else if (free_now) begin
        res_nxt.status      = STAT_NEW;
        res_nxt.entry_count = CNT_W'(1);
      end else begin
        res_nxt.status      = STAT_FULL;
        res_nxt.entry_count = '0;
      end
    end

    if (rep_fin) begin
      res_nxt.status      = STAT_REPORT;
      res_nxt.rank        = rank_ext[RANK_W-1:0];
      res_nxt.entry_id    = found_now ? pick_id : '0;
      res_nxt.entry_count = found_now ? pick_cnt : '0;
      res_nxt.last        = (rank_r == LAST_RANK);
      // Remember the pick so the next rank starts after it
      if (found_now) begin
        prev_cnt_nxt = pick_cnt;
        prev_idx_nxt = pick_idx;
        first_nxt    = 1'b0;
      end
    end

    if (push && (func_r == FUNC_REPORT) && (rank_r != LAST_RANK)) begin
      rank_nxt       = rank_r + 1'b1;
      addr_nxt       = '0;
      iss_done_nxt   = 1'b0;
      best_found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      addr_r     <= '0;
      iss_done_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      iss_done_r <= iss_done_nxt;
      vld_r      <= vld_nxt;
    end
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    vidx_r       <= vidx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_id_r    <= best_id_nxt;
    prev_cnt_r   <= prev_cnt_nxt;
    prev_idx_r   <= prev_idx_nxt;
    first_r      <= first_nxt;
    rank_r       <= rank_nxt;
    res_r        <= res_nxt;
  end

endmodule

>>> src/message_id_frequency_table.sv
// Top level of the message identifier frequency table with top-K report.
// Count transaction: one slot memory read per cycle; a hit ends the scan early.
// Report transaction: TOP_K passes over the slot memory.
// One transaction at a time, the next accepted in the cycle after the last result is pushed,
//   even while it waits. After reset a clearing pass zeroes the counts.
module message_id_frequency_table
  import mift_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int TOP_K       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // can_id[28:0], zero[31:29]
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // rank[3:0], entry_id[32:4], entry_count[64:33], zero[71:65]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free, push;
  res_t              res;
  logic              rd_en, cnt_we, id_we;
  logic [AW-1:0]     rd_addr, cnt_waddr, id_waddr;
  logic [CNT_W-1:0]  cnt_rdata, cnt_wdata;
  logic [ID_W-1:0]   id_rdata, id_wdata;

  assign out_free = !out_valid_r || out_tready;

  mift_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TOP_K       (TOP_K)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser[0]),
    .in_key    (in_tdata[ID_W-1:0]),
    .in_ready  (in_tready),
    .out_free  (out_free),
    .push      (push),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .cnt_rdata (cnt_rdata),
    .id_rdata  (id_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .id_we     (id_we),
    .id_waddr  (id_waddr),
    .id_wdata  (id_wdata)
  );

  mift_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  mift_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (id_rdata)
  );

  // Hold a result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {7'b0, out_res_r.entry_count, out_res_r.entry_id, out_res_r.rank};

endmodule

>>> sim/message_id_frequency_table_tb.sv
// Self-checking testbench of the message identifier frequency table.
`timescale 1ns / 1ps

module message_id_frequency_table_tb;
  import mift_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int TOP_K       = 10;
  localparam int POOL_SIZE   = 44;
  localparam int PHASE_ITEMS = 36;
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = TOP_K * (TABLE_DEPTH + 2) + 20;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    logic              func;
    logic [ID_W-1:0]   can_id;
    bit                typed;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // can_id[28:0], zero[31:29]
  logic [0:0]  in_tuser = '0;    // func[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // rank[3:0], entry_id[32:4], entry_count[64:33], zero[71:65]
  logic [1:0]  out_tuser;        // status[1:0]
  logic        out_tlast;

  // Typed expectation that travels with the transaction being offered.
  bit               cur_typed = 1'b0;
  status_t          cur_status = STAT_HIT;
  logic [CNT_W-1:0] cur_count = '0;

  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  errors = 0;

  logic [ID_W-1:0]  tally_ids [TABLE_DEPTH];
  logic [CNT_W-1:0] tally_counts [TABLE_DEPTH];
  res_t             tally_expected [$];
  logic [ID_W-1:0]  id_pool [POOL_SIZE];
  stim_t            directed_rows [14];

  message_id_frequency_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TOP_K      (TOP_K)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void queue_result(input status_t st, input logic [RANK_W-1:0] rank,
                                       input logic [ID_W-1:0] id,
                                       input logic [CNT_W-1:0] cnt, input logic last);
    res_t r;
    r.status      = st;
    r.rank        = rank;
    r.entry_id    = id;
    r.entry_count = cnt;
    r.last        = last;
    tally_expected.push_back(r);
  endfunction

  // Update the shadow table and queue the results one transaction causes.
  function automatic void predict_tally(input logic func, input logic [ID_W-1:0] id);
    int free_slot;
    int best;
    logic [CNT_W-1:0] best_cnt;
    bit taken [TABLE_DEPTH];
    if (func == FUNC_COUNT) begin
      free_slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tally_counts[i] != '0) begin
          if (tally_ids[i] == id) begin
            if (tally_counts[i] != CNT_MAX) tally_counts[i] = tally_counts[i] + 1'b1;
            queue_result(STAT_HIT, '0, id, tally_counts[i], 1'b1);
            return;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        tally_ids[free_slot]    = id;
        tally_counts[free_slot] = 1;
        queue_result(STAT_NEW, '0, id, 1, 1'b1);
      end else begin
        queue_result(STAT_FULL, '0, id, '0, 1'b1);
      end
      return;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) taken[i] = 1'b0;
    for (int r = 0; r < TOP_K; r++) begin
      best = -1;
      best_cnt = '0;
      // Strict compare keeps ties on the lower slot.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!taken[i] && tally_counts[i] > best_cnt) begin
          best = i;
          best_cnt = tally_counts[i];
        end
      end
      if (best >= 0) begin
        taken[best] = 1'b1;
        queue_result(STAT_REPORT, r[RANK_W-1:0], tally_ids[best], best_cnt, r == TOP_K - 1);
      end else begin
        queue_result(STAT_REPORT, r[RANK_W-1:0], '0, '0, r == TOP_K - 1);
      end
    end
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    s.typed  = 1'b0;
    s.status = STAT_HIT;
    s.count  = '0;
    s.can_id = ID_W'($urandom);
    if ($urandom_range(7) == 0) begin
      s.func = FUNC_REPORT;
    end else begin
      s.func = FUNC_COUNT;
      // Mostly revisit a pool a bit larger than the table so it fills and then drops.
      if ($urandom_range(7) != 0) s.can_id = id_pool[$urandom_range(POOL_SIZE - 1)];
      else if ($urandom_range(1) == 0) s.can_id = ID_W'($urandom_range(2047));
    end
    return s;
  endfunction

  task automatic send_item(input stim_t s, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {3'b000, s.can_id};
    in_tuser   <= s.func;
    cur_typed  <= s.typed;
    cur_status <= s.status;
    cur_count  <= s.count;
    do @(posedge clk); while (!in_tready);
  endtask

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_tally(in_tuser[0], in_tdata[ID_W-1:0]);
      if (cur_typed) begin
        tally_expected[$].status      = cur_status;
        tally_expected[$].rank        = '0;
        tally_expected[$].entry_id    = in_tdata[ID_W-1:0];
        tally_expected[$].entry_count = cur_count;
        tally_expected[$].last        = 1'b1;
      end
    end
  end

  // Check every accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = status_t'(out_tuser);
      got.rank        = out_tdata[3:0];
      got.entry_id    = out_tdata[32:4];
      got.entry_count = out_tdata[64:33];
      got.last        = out_tlast;
      if (tally_expected.size() == 0) begin
        if (errors < SHOWN_ERRORS)
          $display("unexpected result: st=%0d rk=%0d id=%h cnt=%0d last=%0b",
                   got.status, got.rank, got.entry_id, got.entry_count, got.last);
        errors++;
      end else begin
        want = tally_expected.pop_front();
        if (got.status != want.status || got.rank != want.rank ||
            got.entry_id != want.entry_id || got.entry_count != want.entry_count ||
            got.last != want.last) begin
          if (errors < SHOWN_ERRORS) begin
            $display("mismatch: exp st=%0d rk=%0d id=%h cnt=%0d last=%0b",
                     want.status, want.rank, want.entry_id, want.entry_count, want.last);
            $display("          got st=%0d rk=%0d id=%h cnt=%0d last=%0b",
                     got.status, got.rank, got.entry_id, got.entry_count, got.last);
          end
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("** message_id_frequency_table: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int send_idle_pct;
    stim_t s;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tally_ids[i]    = '0;
      tally_counts[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    directed_rows = '{
      // empty report right after reset
      '{FUNC_REPORT, 29'h0000000,  1'b0, STAT_REPORT, 32'd0},
      '{FUNC_COUNT,  29'h1FFFFFFF, 1'b1, STAT_NEW,    32'd1},
      '{FUNC_COUNT,  29'h0000000,  1'b1, STAT_NEW,    32'd1},
      '{FUNC_COUNT,  29'h0000000,  1'b1, STAT_HIT,    32'd2},
      '{FUNC_COUNT,  29'h1FFFFFFF, 1'b1, STAT_HIT,    32'd2},
      // tie on count two: lower slot ranks first
      '{FUNC_REPORT, 29'h0000000,  1'b0, STAT_REPORT, 32'd0},
      '{FUNC_COUNT,  29'h0AAAAAAA, 1'b1, STAT_NEW,    32'd1},
      '{FUNC_COUNT,  29'h15555555, 1'b1, STAT_NEW,    32'd1},
      '{FUNC_COUNT,  29'h15555555, 1'b1, STAT_HIT,    32'd2},
      '{FUNC_COUNT,  29'h15555555, 1'b1, STAT_HIT,    32'd3},
      // report ignores its identifier
      '{FUNC_REPORT, 29'h1FFFFFFF, 1'b0, STAT_REPORT, 32'd0},
      '{FUNC_COUNT,  29'h00007FF,  1'b1, STAT_NEW,    32'd1},
      '{FUNC_COUNT,  29'h0000800,  1'b1, STAT_NEW,    32'd1},
      '{FUNC_REPORT, 29'h0ABCDEF,  1'b0, STAT_REPORT, 32'd0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 0;
    foreach (directed_rows[i]) send_item(directed_rows[i], send_idle_pct);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          send_idle_pct = 74;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 74;
        end
        3: begin
          send_idle_pct = 36;
          recv_stall_pct <= 36;
        end
        4: begin
          // keep offering while the receiver holds off
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_req <= 1'b1;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = random_item();
        send_item(s, send_idle_pct);
      end
    end
    in_tvalid <= 1'b0;

    while (tally_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && tally_expected.size() == 0) begin
      $display("** message_id_frequency_table: PASSED **");
    end else begin
      $display("** message_id_frequency_table: FAILED **");
    end
    $finish;
  end

endmodule
